/* hdl/kepler_ea_pkg.sv */
// Shared types and constants for the Kepler eccentric-anomaly series block.
// Coefficient term table, sine polynomial reciprocal constants, fixed-point scales.
// No dependencies.
package kepler_ea_pkg;

  localparam int FRAC = 30;
  localparam int LANES = 7;
  localparam int SIN_STEPS = 7;
  localparam int NUM_TERMS = 15;
  localparam int ECC_RESET = 1094;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

  // Nested Taylor sine: h = 1 - (r2*h)/div, div from the innermost term out.
  // Exact floor division of a 32-bit value: (x * RECIP) >> (32 + SHIFT).
  localparam logic [7:0] SIN_DIV [SIN_STEPS] = '{8'd210, 8'd156, 8'd110, 8'd72,
                                                 8'd42, 8'd20, 8'd6};
  localparam int SIN_SHIFT [SIN_STEPS] = '{8, 8, 7, 7, 6, 5, 3};
  localparam logic [32:0] SIN_RECIP [SIN_STEPS] = '{
    33'(((64'd1 << 40) / 64'd210) + 64'd1),
    33'(((64'd1 << 40) / 64'd156) + 64'd1),
    33'(((64'd1 << 39) / 64'd110) + 64'd1),
    33'(((64'd1 << 39) / 64'd72) + 64'd1),
    33'(((64'd1 << 38) / 64'd42) + 64'd1),
    33'(((64'd1 << 37) / 64'd20) + 64'd1),
    33'(((64'd1 << 35) / 64'd6) + 64'd1)
  };

  // One series term: coef[lane] +/- (num * e^(pidx+1)) / den
  typedef struct packed {
    logic [2:0]  lane;
    logic [2:0]  pidx;
    logic [14:0] num;
    logic [15:0] den;
    logic        sub;
  } term_t;

  localparam term_t TERMS [NUM_TERMS] = '{
    '{3'd0, 3'd2, 15'd1,     16'd8,     1'b1},
    '{3'd0, 3'd4, 15'd1,     16'd192,   1'b0},
    '{3'd0, 3'd6, 15'd1,     16'd9216,  1'b1},
    '{3'd1, 3'd1, 15'd1,     16'd2,     1'b0},
    '{3'd1, 3'd3, 15'd1,     16'd6,     1'b1},
    '{3'd1, 3'd5, 15'd1,     16'd48,    1'b0},
    '{3'd2, 3'd2, 15'd3,     16'd8,     1'b0},
    '{3'd2, 3'd4, 15'd27,    16'd128,   1'b1},
    '{3'd2, 3'd6, 15'd243,   16'd5120,  1'b0},
    '{3'd3, 3'd3, 15'd1,     16'd3,     1'b0},
    '{3'd3, 3'd5, 15'd4,     16'd15,    1'b1},
    '{3'd4, 3'd4, 15'd125,   16'd384,   1'b0},
    '{3'd4, 3'd6, 15'd3125,  16'd9216,  1'b1},
    '{3'd5, 3'd5, 15'd27,    16'd80,    1'b0},
    '{3'd6, 3'd6, 15'd16807, 16'd46080, 1'b0}
  };

  // Exact floor division of a term product below 2^TERM_BITS by its den:
  // (x * TERM_RECIP) >> TERM_SHIFT, recip = ceil(2^shift / den).
  localparam int TERM_BITS = 45;

  function automatic int term_shift(int d);
    return TERM_BITS + $clog2(d);
  endfunction

  function automatic logic [45:0] term_recip(int d);
    logic [63:0] p;
    p = 64'd1 << term_shift(d);
    return 46'((p + 64'(d) - 64'd1) / 64'(d));
  endfunction

  // Same order as TERMS.
  localparam logic [5:0] TERM_SHIFT [NUM_TERMS] = '{
    6'(term_shift(8)),    6'(term_shift(192)),  6'(term_shift(9216)),
    6'(term_shift(2)),    6'(term_shift(6)),    6'(term_shift(48)),
    6'(term_shift(8)),    6'(term_shift(128)),  6'(term_shift(5120)),
    6'(term_shift(3)),    6'(term_shift(15)),   6'(term_shift(384)),
    6'(term_shift(9216)), 6'(term_shift(80)),   6'(term_shift(46080))
  };

  localparam logic [45:0] TERM_RECIP [NUM_TERMS] = '{
    term_recip(8),    term_recip(192),  term_recip(9216),
    term_recip(2),    term_recip(6),    term_recip(48),
    term_recip(8),    term_recip(128),  term_recip(5120),
    term_recip(3),    term_recip(15),   term_recip(384),
    term_recip(9216), term_recip(80),   term_recip(46080)
  };

endpackage

/* hdl/kepler_eccentric_anomaly_series.sv */
// Kepler equation solver, seventh-order eccentricity series, fully pipelined.
// Depends on kepler_ea_pkg (term table, sine constants).
//
// Usage:
//  - Input channel in_valid/in_ready carries one mean_anomaly item (turn fraction).
//  - Output channel out_valid/out_ready returns eccentric_anomaly, one per item,
//    in order.
//  - Config channel cfg_valid/cfg_ready writes eccentricity (Q0.ECC_BITS), capped
//    at the series convergence limit. cfg_ready is always high.
//  - Throughput is one item per cycle unless out_ready stalls it. The 24 stages are:
//    fold, radian scale, square, seven sine polynomial steps of two stages each
//    (multiply, divide by reciprocal), sine finish, coefficient product, a
//    three-level adder tree, scale to turns, round and add.
//  - The seven series coefficients are rebuilt by a small sequencer after reset
//    and after every config write: the powers of e up to the seventh, then for each
//    of the 15 terms a term product, a four-step reciprocal multiply and an accumulate.
//    in_ready stays low until it is done.
//  - Reset (rst, synchronous) empties the pipeline and loads eccentricity 1094.
//  - Each stage holds its item while the next stage cannot load, so a stalled receiver
//    fills the pipeline bubble by bubble; nothing is lost or repeated.
module kepler_eccentric_anomaly_series #(
  parameter int ANGLE_BITS = 32,
  parameter int ECC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ANGLE_BITS-1:0] mean_anomaly,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ANGLE_BITS-1:0] eccentric_anomaly,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [ECC_BITS-1:0]   eccentricity
);

  localparam int AB = ANGLE_BITS;
  localparam int NL = kepler_ea_pkg::LANES;
  localparam int NS = kepler_ea_pkg::SIN_STEPS;
  localparam int NST = 24;
  localparam int S_SIN = 17;
  localparam int S_PROD = 18;
  localparam int S_SUM1 = 19;
  localparam int S_SUM2 = 20;
  localparam int S_SUM3 = 21;
  localparam int S_TURN = 22;
  localparam int S_OUT = 23;
  localparam int RSH = 62 - AB;
  localparam logic [ECC_BITS-1:0] ECC_MAX =
    ECC_BITS'(((64'd1 << ECC_BITS) * 64'd66270) / 64'd100000);

  localparam logic [2:0] ST_POW  = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_RMUL = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // ---------------- coefficient sequencer ----------------
  logic [2:0]          state;
  logic [ECC_BITS-1:0] ecc_value;
  logic [2:0]          pidx;
  logic [3:0]          ti;
  logic [1:0]          mstep;
  logic [44:0]         xval;
  logic [90:0]         pacc;
  logic [29:0]         pw [NL];
  logic signed [31:0]  coef [NL];

  logic [ECC_BITS-1:0] ev_cap;
  logic [29:0]         e1;
  logic [45:0]         recip;
  logic [5:0]          rshift;
  logic [22:0]         mul_a;
  logic [22:0]         mul_b;
  logic [45:0]         pp;
  logic [90:0]         pp_sh;
  logic [90:0]         quot;
  kepler_ea_pkg::term_t cur;

  always_comb begin
    ev_cap = (ecc_value > ECC_MAX) ? ECC_MAX : ecc_value;
    e1 = 30'(({ev_cap, 30'b0}) >> ECC_BITS);
    cur = kepler_ea_pkg::TERMS[ti];
    recip = kepler_ea_pkg::TERM_RECIP[ti];
    rshift = kepler_ea_pkg::TERM_SHIFT[ti];
    // xval * recip as four 23x23 partial products, one per cycle
    mul_a = mstep[1] ? {1'b0, xval[44:23]} : xval[22:0];
    mul_b = mstep[0] ? recip[45:23] : recip[22:0];
    pp = {23'd0, mul_a} * {23'd0, mul_b};
    case (mstep)
      2'd0: pp_sh = 91'(pp);
      2'd3: pp_sh = 91'(pp) << 46;
      default: pp_sh = 91'(pp) << 23;
    endcase
    quot = pacc >> rshift;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_POW;
      pidx <= 3'd0;
      ecc_value <= ECC_BITS'(kepler_ea_pkg::ECC_RESET);
    end else if (cfg_valid && cfg_ready) begin
      state <= ST_POW;
      pidx <= 3'd0;
      ecc_value <= eccentricity;
    end else begin
      case (state)
        ST_POW: begin
          if (pidx == 3'd0) begin
            pw[0] <= e1;
          end else begin
            pw[pidx] <= 30'((60'(pw[pidx - 3'd1]) * 60'(pw[0])) >> kepler_ea_pkg::FRAC);
          end
          if (pidx == 3'd6) begin
            state <= ST_MUL;
            ti <= 4'd0;
            for (int k = 1; k < NL; k++) coef[k] <= 32'sd0;
            coef[0] <= $signed({2'b00, pw[0]});
          end
          pidx <= pidx + 3'd1;
        end
        ST_MUL: begin
          xval <= 45'(cur.num) * 45'(pw[cur.pidx]);
          pacc <= '0;
          mstep <= 2'd0;
          state <= ST_RMUL;
        end
        ST_RMUL: begin
          pacc <= pacc + pp_sh;
          mstep <= mstep + 2'd1;
          if (mstep == 2'd3) state <= ST_ADD;
        end
        ST_ADD: begin
          coef[cur.lane] <= cur.sub ? coef[cur.lane] - $signed(32'(quot))
                                    : coef[cur.lane] + $signed(32'(quot));
          if (ti == 4'(kepler_ea_pkg::NUM_TERMS - 1)) begin
            state <= ST_DONE;
          end else begin
            ti <= ti + 4'd1;
            state <= ST_MUL;
          end
        end
        ST_DONE: begin
          state <= ST_DONE;
        end
        default: begin
          state <= ST_POW;
          pidx <= 3'd0;
        end
      endcase
    end
  end

  // ---------------- item pipeline ----------------
  logic [NST-1:0]     vld;
  logic [NST-1:0]     en;
  logic [AB-1:0]      mq    [0:S_TURN];
  logic [NL-1:0]      negs  [0:16];
  logic [30:0]        q_q   [NL];
  logic [30:0]        r_q   [1:16][NL];
  logic [31:0]        r2_q  [2:15][NL];
  logic [31:0]        x_q   [NS][NL];
  logic [30:0]        h_q   [NS][NL];
  logic signed [31:0] sin_q [NL];
  logic signed [63:0] prod  [NL];
  logic signed [63:0] sum1  [4];
  logic signed [63:0] sum2  [2];
  logic signed [63:0] acc;
  logic signed [63:0] turns;

  logic [30:0]        fold_q   [NL];
  logic [NL-1:0]      fold_neg;
  logic [30:0]        rn       [NL];
  logic [31:0]        r2n      [NL];
  logic [31:0]        xn       [NS][NL];
  logic [30:0]        hn       [NS][NL];
  logic [30:0]        hprev;
  logic [30:0]        yq;
  logic [30:0]        sn       [NL];
  logic [AB-1:0]      km;
  logic [AB+31:0]     wide;
  logic [31:0]        ph;
  logic [31:0]        qext;
  logic signed [33:0] corr;
  logic signed [63:0] rnd;
  logic [AB-1:0]      delta;

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      km = AB'(mean_anomaly * AB'(k + 1));
      wide = {km, 32'b0} >> AB;
      ph = wide[31:0];
      fold_neg[k] = ph[31];
      qext = {1'b0, ph[30:0]};
      if (qext > 32'(kepler_ea_pkg::ONE_Q30)) qext = 32'h8000_0000 - qext;
      fold_q[k] = qext[30:0];
      rn[k] = 31'((62'(q_q[k]) * 62'(kepler_ea_pkg::HALF_PI_Q30)) >> kepler_ea_pkg::FRAC);
      r2n[k] = 32'((62'(r_q[1][k]) * 62'(r_q[1][k])) >> kepler_ea_pkg::FRAC);
      sn[k] = 31'((62'(r_q[16][k]) * 62'(h_q[NS-1][k])) >> kepler_ea_pkg::FRAC);
    end
    for (int i = 0; i < NS; i++) begin
      for (int k = 0; k < NL; k++) begin
        hprev = (i == 0) ? kepler_ea_pkg::ONE_Q30 : h_q[(i == 0) ? 0 : i - 1][k];
        xn[i][k] = 32'((63'(r2_q[2 + 2 * i][k]) * 63'(hprev)) >> kepler_ea_pkg::FRAC);
        yq = 31'((65'(x_q[i][k]) * 65'(kepler_ea_pkg::SIN_RECIP[i]))
                 >> (32 + kepler_ea_pkg::SIN_SHIFT[i]));
        hn[i][k] = kepler_ea_pkg::ONE_Q30 - yq;
      end
    end
    corr = 34'(acc >>> kepler_ea_pkg::FRAC);
    rnd = turns + (64'sd1 <<< (RSH - 1));
    delta = AB'(rnd >>> RSH);
  end

  // Each stage loads when it is empty or the next stage loads too.
  always_comb begin
    en[NST-1] = !vld[NST-1] || out_ready;
    for (int j = NST - 2; j >= 0; j--) en[j] = !vld[j] || en[j+1];
  end

  assign in_ready = en[0] && (state == ST_DONE);
  assign out_valid = vld[S_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid && (state == ST_DONE);
      for (int j = 1; j < NST; j++) begin
        if (en[j]) vld[j] <= vld[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mq[0] <= mean_anomaly;
      negs[0] <= fold_neg;
      for (int k = 0; k < NL; k++) q_q[k] <= fold_q[k];
    end
    for (int j = 1; j <= S_TURN; j++) begin
      if (en[j]) mq[j] <= mq[j-1];
    end
    for (int j = 1; j <= 16; j++) begin
      if (en[j]) negs[j] <= negs[j-1];
    end
    if (en[1]) begin
      for (int k = 0; k < NL; k++) r_q[1][k] <= rn[k];
    end
    for (int j = 2; j <= 16; j++) begin
      if (en[j]) r_q[j] <= r_q[j-1];
    end
    if (en[2]) begin
      for (int k = 0; k < NL; k++) r2_q[2][k] <= r2n[k];
    end
    for (int j = 3; j <= 15; j++) begin
      if (en[j]) r2_q[j] <= r2_q[j-1];
    end
    for (int i = 0; i < NS; i++) begin
      if (en[3 + 2 * i]) x_q[i] <= xn[i];
      if (en[4 + 2 * i]) h_q[i] <= hn[i];
    end
    if (en[S_SIN]) begin
      for (int k = 0; k < NL; k++) begin
        sin_q[k] <= negs[16][k] ? -$signed({1'b0, sn[k]}) : $signed({1'b0, sn[k]});
      end
    end
    if (en[S_PROD]) begin
      for (int k = 0; k < NL; k++) prod[k] <= 64'(coef[k] * sin_q[k]);
    end
    if (en[S_SUM1]) begin
      sum1[0] <= prod[0] + prod[1];
      sum1[1] <= prod[2] + prod[3];
      sum1[2] <= prod[4] + prod[5];
      sum1[3] <= prod[6];
    end
    if (en[S_SUM2]) begin
      sum2[0] <= sum1[0] + sum1[1];
      sum2[1] <= sum1[2] + sum1[3];
    end
    if (en[S_SUM3]) acc <= sum2[0] + sum2[1];
    if (en[S_TURN]) turns <= 64'(corr * $signed({1'b0, kepler_ea_pkg::INV_TWO_PI_Q32}));
    if (en[S_OUT]) eccentric_anomaly <= mq[S_TURN] + delta;
  end

  // ---------------- checks ----------------
  a_no_accept_while_building: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DONE) |-> !in_ready)
    else $error("input accepted while coefficients are being rebuilt");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(eccentric_anomaly))
    else $error("stalled result dropped or changed");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (state == ST_POW) && (pidx == 3'd0))
    else $error("config write did not restart coefficient build");

  a_pow_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POW) |-> (pidx <= 3'd6))
    else $error("power index overran");

endmodule

/* sim/tb.sv */
// Self-checking bench for kepler_eccentric_anomaly_series.
// Needs kepler_ea_pkg and the block itself. A scoreboard class predicts each
// eccentric anomaly from the mean anomaly and the current eccentricity.
class ea_scoreboard;
  bit [15:0]  ecc;
  bit [31:0]  pending[$];
  int         errors;

  function new();
    ecc = 16'(kepler_ea_pkg::ECC_RESET);
    errors = 0;
  endfunction

  // Signed Q30 sine of a 32-bit turn fraction, truncating Taylor series.
  function longint sine_q30(bit [31:0] ph);
    bit [63:0] divs[7];
    bit [63:0] q, r, r2, h;
    divs = '{210, 156, 110, 72, 42, 20, 6};
    q = {33'd0, ph[30:0]};
    if (q > 64'h4000_0000) begin
      q = (64'd1 << 31) - q;
    end
    r = (q * 64'd1686629713) >> 30;
    r2 = (r * r) >> 30;
    h = 64'h4000_0000;
    for (int i = 0; i < 7; i++) begin
      h = 64'h4000_0000 - ((r2 * h) >> 30) / divs[i];
    end
    r = (r * h) >> 30;
    return ph[31] ? -longint'(r) : longint'(r);
  endfunction

  function bit [31:0] eccentric_anomaly_of(bit [31:0] m);
    bit [63:0] ev, e1, e2, e3, e4, e5, e6, e7, km, delta, corr_u;
    longint    coef[7];
    longint    acc, corr30, turns;
    ev = ecc;
    if (ev > 64'd43430) begin
      ev = 64'd43430;  // capped below series convergence
    end
    e1 = (ev << 30) >> 16;
    e2 = (e1 * e1) >> 30;
    e3 = (e2 * e1) >> 30;
    e4 = (e3 * e1) >> 30;
    e5 = (e4 * e1) >> 30;
    e6 = (e5 * e1) >> 30;
    e7 = (e6 * e1) >> 30;
    coef[0] = longint'(e1) - longint'(e3 / 8) + longint'(e5 / 192) - longint'(e7 / 9216);
    coef[1] = longint'(e2 / 2) - longint'(e4 / 6) + longint'(e6 / 48);
    coef[2] = longint'(3 * e3 / 8) - longint'(27 * e5 / 128) + longint'(243 * e7 / 5120);
    coef[3] = longint'(e4 / 3) - longint'(4 * e6 / 15);
    coef[4] = longint'(125 * e5 / 384) - longint'(3125 * e7 / 9216);
    coef[5] = longint'(27 * e6 / 80);
    coef[6] = longint'(16807 * e7 / 46080);
    acc = 0;
    for (int k = 0; k < 7; k++) begin
      km = (64'(m) * 64'(k + 1)) & 64'hFFFF_FFFF;
      acc += coef[k] * sine_q30(km[31:0]);
    end
    // floor Q60 to Q30 radians, then to Q62 turns
    corr_u = (64'(acc) + (64'd1 << 62)) >> 30;
    corr30 = longint'(corr_u) - longint'(64'd1 << 32);
    turns = corr30 * longint'(683565276);
    delta = ((64'(turns) + (64'd1 << 62) + (64'd1 << 29)) >> 30) - (64'd1 << 32);
    return m + delta[31:0];
  endfunction

  function void note_input(bit [31:0] m);
    pending = {pending, eccentric_anomaly_of(m)};
  endfunction

  function void check_result(bit [31:0] got);
    bit [31:0] want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected eccentric_anomaly %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      $display("%0t: eccentric_anomaly expected %h actual %h", $time, want, got);
      errors++;
    end
  endfunction
endclass

module tb;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] mean_anomaly = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] eccentric_anomaly;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] eccentricity = '0;

  ea_scoreboard sb = new();
  int           quiet_cycles = 0;
  bit           burst;  // sender runs with no gaps while set

  kepler_eccentric_anomaly_series uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .mean_anomaly(mean_anomaly),
    .out_valid(out_valid), .out_ready(out_ready), .eccentric_anomaly(eccentric_anomaly),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .eccentricity(eccentricity)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Handshake monitors: inputs feed the predictor, outputs are checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.ecc = eccentricity;
      if (in_valid && in_ready) sb.note_input(mean_anomaly);
      if (out_valid && out_ready) sb.check_result(eccentric_anomaly);
    end
  end

  // Watchdog: if no handshake is seen on any channel for longer than a coefficient
  // rebuild plus the longest stall, the block is stuck and the run fails.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("** kepler_eccentric_anomaly_series: FAILED **");
      $finish;
    end
  end

  // Receiver: random stall before each item, sometimes none at all.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input bit [31:0] m);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mean_anomaly <= m;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_ecc(input bit [15:0] v);
    cfg_valid <= 1'b1;
    eccentricity <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random angle, biased toward quadrant edges now and then.
  function automatic bit [31:0] rand_angle();
    bit [31:0] a;
    a = $urandom;
    if ($urandom_range(0, 7) == 0) a = {a[31:30], 30'd0} + $urandom_range(0, 4) - 2;
    return a;
  endfunction

  initial begin
    bit [31:0] directed[$];
    bit [15:0] settings[$];
    directed = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h4000_0000, 32'hC000_0000,
                 32'h3FFF_FFFF, 32'h4000_0001, 32'h0000_0001, 32'h7FFF_FFFF,
                 32'h8000_0001, 32'h2000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'h1555_5555, 32'hBFFF_FFFF, 32'hC000_0001};
    // reset value first (no write), then zero, the cap, above the cap, full scale
    settings = '{16'd0, 16'd43430, 16'd43431, 16'hFFFF, 16'd1, 16'd21845,
                 16'(  $urandom_range(0, 43430)), 16'(  $urandom)};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    burst = 0;
    foreach (directed[i]) send_item(directed[i]);
    for (int ph = 0; ph <= settings.size(); ph++) begin
      if (ph > 0) begin
        drain();
        write_ecc(settings[ph - 1]);
        foreach (directed[i]) if (i < 4) send_item(directed[i]);
      end
      for (int i = 0; i < 125; i++) begin
        if (i % 25 == 0) burst = $urandom_range(0, 1);
        if (ph == 2 && i == 60) begin
          // hold the sender until the pipeline has fully emptied
          in_valid <= 1'b0;
          do @(posedge clk); while (sb.pending.size() != 0);
        end
        send_item(rand_angle());
      end
    end
    drain();
    if (sb.errors == 0)
      $display("** kepler_eccentric_anomaly_series: PASSED **");
    else
      $display("** kepler_eccentric_anomaly_series: FAILED **");
    $finish;
  end
endmodule
